// File: rtl/cstc_pkg.sv
// shared types, opcodes and state update functions for clock source transport control
package cstc_pkg;

	// event opcodes
	localparam logic [3:0] OP_TICK        = 4'd0;
	localparam logic [3:0] OP_START       = 4'd1;
	localparam logic [3:0] OP_STOP        = 4'd2;
	localparam logic [3:0] OP_GATE        = 4'd3;
	localparam logic [3:0] OP_WATCHDOG    = 4'd4;
	localparam logic [3:0] OP_SET_FOLLOW  = 4'd5;
	localparam logic [3:0] OP_SET_SOURCE  = 4'd6;
	localparam logic [3:0] OP_SET_LATCH   = 4'd7;
	localparam logic [3:0] OP_TOGGLE_PROV = 4'd8;
	localparam logic [3:0] OP_RESET_TRANS = 4'd9;
	localparam logic [3:0] OP_CLEAR_HOLD  = 4'd10;
	localparam logic [3:0] OP_REFRESH_LAT = 4'd11;
	localparam logic [3:0] OP_TOGGLE_LAT  = 4'd12;
	localparam logic [3:0] OP_PRESET      = 4'd13;

	// run flag bits
	localparam logic [2:0] RUN_INT = 3'b001;
	localparam logic [2:0] RUN_IN  = 3'b010;
	localparam logic [2:0] RUN_OUT = 3'b100;
	localparam logic [2:0] RUN_RST = RUN_INT | RUN_OUT;

	localparam logic [31:0] TIMEOUT_RST = 32'd1000;

	// classified event as it travels from front to back
	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] now_ms;
		logic        gate_high;
		logic        fa;
		logic        fb;
		logic        fc;
	} cmd_t;

	// transport control state
	typedef struct packed {
		logic        src_is_ext;
		logic        follow_ext;
		logic        ext_running;
		logic        latch_on;
		logic        latch_run;
		logic        gate_held;
		logic        dominant;
		logic [31:0] last_tick_ms;
		logic [31:0] wait_start_ms;
		logic [2:0]  run_flags;
	} state_t;

	function automatic state_t align_runs(state_t s);
		state_t r;
		r = s;
		if (!r.src_is_ext)
			r.run_flags = RUN_INT | RUN_OUT;
		else
			r.run_flags = r.ext_running ? (RUN_IN | RUN_OUT) : 3'b000;
		return r;
	endfunction

	function automatic state_t pick_source(state_t s, logic ext);
		state_t r;
		r = s;
		r.src_is_ext = ext;
		return align_runs(r);
	endfunction

	function automatic state_t update_dominance(state_t s);
		state_t r;
		r = s;
		r.dominant = r.follow_ext | r.ext_running;
		return r;
	endfunction

	function automatic state_t transport_start(state_t s);
		state_t r;
		r = s;
		r.ext_running = 1'b1;
		r = pick_source(r, 1'b1);
		r = update_dominance(r);
		if (r.latch_on)
			r.latch_run = 1'b1;
		return r;
	endfunction

	function automatic state_t transport_stop(state_t s);
		state_t r;
		r = s;
		r.ext_running = 1'b0;
		if (!r.follow_ext)
			r = pick_source(r, 1'b0);
		else
			r = align_runs(r);
		r = update_dominance(r);
		if (r.latch_on)
			r.latch_run = 1'b0;
		return r;
	endfunction

	function automatic state_t fall_back(state_t s);
		state_t r;
		r = s;
		r.follow_ext = 1'b0;
		r = pick_source(r, 1'b0);
		r = update_dominance(r);
		r.wait_start_ms = '0;
		r.last_tick_ms = '0;
		return r;
	endfunction

endpackage

// File: rtl/cstc_front.sv
// front stage: takes input beats and classifies them into commands
module cstc_front
	import cstc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [31:0] now_ms,
	input  logic [7:0]  gate_level,
	input  logic        flag_a,
	input  logic        flag_b,
	input  logic        flag_c,
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        queue_full
);

	logic valid_s1;
	cmd_t cmd_s1;

	// stage drains whenever the queue has room
	assign push     = valid_s1 & ~queue_full;
	assign in_ready = ~valid_s1 | ~queue_full;
	assign push_cmd = cmd_s1;

	// valid bit of the classify stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// classified payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.op        <= opcode;
			cmd_s1.now_ms    <= now_ms;
			cmd_s1.gate_high <= |gate_level;
			cmd_s1.fa        <= flag_a;
			cmd_s1.fb        <= flag_b;
			cmd_s1.fc        <= flag_c;
		end
	end

endmodule

// File: rtl/cstc_queue.sv
// short command queue between front and back
module cstc_queue
	import cstc_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// no overflow or underflow from either side
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// File: rtl/cstc_back.sv
// back stage: executes commands on the transport state and registers results
module cstc_back
	import cstc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        queue_empty,
	input  cmd_t        head_cmd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        source_external,
	output logic        internal_run,
	output logic        midi_in_run,
	output logic        midi_out_run,
	output logic        external_dominant,
	output logic        latched_running,
	output logic        follow_enabled,
	output logic        fell_back
);

	logic [31:0] timeout_q;
	state_t      st_q;
	state_t      st_nxt;
	logic        fell_nxt;
	logic        out_valid_q;
	logic        fell_q;
	state_t      res_q;

	// execute when a command waits and the result register is free
	assign pop = ~queue_empty & (~out_valid_q | out_ready);

	// next state for the command at the head of the queue
	always_comb begin
		logic [31:0] ref_ms;
		logic [31:0] elapsed;
		logic        prev_latch;
		st_nxt     = st_q;
		fell_nxt   = 1'b0;
		ref_ms     = '0;
		elapsed    = '0;
		prev_latch = st_q.latch_on;
		case (head_cmd.op)
			OP_TICK: begin
				st_nxt.last_tick_ms  = head_cmd.now_ms;
				st_nxt.wait_start_ms = '0;
				st_nxt.ext_running   = 1'b1;
				st_nxt = align_runs(st_nxt);
				st_nxt = update_dominance(st_nxt);
			end
			OP_START: st_nxt = transport_start(st_nxt);
			OP_STOP:  st_nxt = transport_stop(st_nxt);
			OP_GATE: begin
				if (st_q.latch_on) begin
					if (head_cmd.gate_high && !st_q.gate_held) begin
						st_nxt.gate_held = 1'b1;
						if (st_q.latch_run)
							st_nxt = transport_stop(st_nxt);
						else
							st_nxt = transport_start(st_nxt);
					end else if (!head_cmd.gate_high) begin
						st_nxt.gate_held = 1'b0;
					end
				end else if (head_cmd.gate_high) begin
					st_nxt = transport_start(st_nxt);
				end else begin
					st_nxt = transport_stop(st_nxt);
				end
			end
			OP_WATCHDOG: begin
				if (!st_q.follow_ext) begin
					st_nxt.wait_start_ms = '0;
				end else begin
					if (st_q.last_tick_ms == '0) begin
						if (st_q.wait_start_ms == '0)
							st_nxt.wait_start_ms = head_cmd.now_ms;
						ref_ms = st_nxt.wait_start_ms;
					end else begin
						ref_ms = st_q.last_tick_ms;
					end
					elapsed = head_cmd.now_ms - ref_ms;
					if (elapsed >= timeout_q) begin
						st_nxt   = fall_back(st_nxt);
						fell_nxt = 1'b1;
					end
				end
			end
			OP_SET_FOLLOW: begin
				if (st_q.follow_ext != head_cmd.fa) begin
					st_nxt.follow_ext = head_cmd.fa;
					st_nxt = pick_source(st_nxt, head_cmd.fa);
					st_nxt = update_dominance(st_nxt);
					st_nxt.wait_start_ms = head_cmd.fa ? head_cmd.now_ms : '0;
					st_nxt.last_tick_ms  = '0;
				end
			end
			OP_SET_SOURCE: begin
				st_nxt = pick_source(st_nxt, head_cmd.fa);
				st_nxt.follow_ext = head_cmd.fa;
				st_nxt = update_dominance(st_nxt);
				st_nxt.wait_start_ms = head_cmd.fa ? head_cmd.now_ms : '0;
				st_nxt.last_tick_ms  = '0;
			end
			OP_SET_LATCH: begin
				if (st_q.latch_on != head_cmd.fa) begin
					st_nxt.latch_on = head_cmd.fa;
					if (head_cmd.fa) begin
						st_nxt.latch_run = st_q.ext_running;
					end else begin
						st_nxt.latch_run = 1'b0;
						st_nxt.gate_held = 1'b0;
					end
				end
			end
			OP_TOGGLE_PROV: begin
				if (!st_q.src_is_ext) begin
					st_nxt = pick_source(st_nxt, 1'b1);
					st_nxt.follow_ext = 1'b1;
				end else begin
					st_nxt = pick_source(st_nxt, 1'b0);
					st_nxt.follow_ext = 1'b0;
				end
				st_nxt = update_dominance(st_nxt);
			end
			OP_RESET_TRANS: begin
				st_nxt.ext_running = 1'b0;
				st_nxt.latch_run   = 1'b0;
				st_nxt.gate_held   = 1'b0;
				st_nxt = update_dominance(st_nxt);
			end
			OP_CLEAR_HOLD: st_nxt.gate_held = 1'b0;
			OP_REFRESH_LAT: begin
				if (st_q.latch_on)
					st_nxt.latch_run = st_q.ext_running;
			end
			OP_TOGGLE_LAT: st_nxt.latch_run = ~st_q.latch_run;
			OP_PRESET: begin
				st_nxt.follow_ext = head_cmd.fa;
				st_nxt.latch_on   = head_cmd.fb;
				if (!head_cmd.fb) begin
					st_nxt.latch_run = 1'b0;
					st_nxt.gate_held = 1'b0;
				end else if (!prev_latch) begin
					st_nxt.latch_run = head_cmd.fc;
				end
				st_nxt.ext_running = head_cmd.fc;
				st_nxt = update_dominance(st_nxt);
			end
			default: begin
				st_nxt = st_q;
			end
		endcase
	end

	// watchdog timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TIMEOUT_RST;
		else if (cfg_write)
			timeout_q <= cfg_data;
	end

	// transport state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{run_flags: RUN_RST, default: '0};
		end else if (pop) begin
			st_q <= st_nxt;
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q  <= st_nxt;
			fell_q <= fell_nxt;
		end
	end

	assign out_valid         = out_valid_q;
	assign source_external   = res_q.src_is_ext;
	assign internal_run      = |(res_q.run_flags & RUN_INT);
	assign midi_in_run       = |(res_q.run_flags & RUN_IN);
	assign midi_out_run      = |(res_q.run_flags & RUN_OUT);
	assign external_dominant = res_q.dominant;
	assign latched_running   = res_q.latch_run;
	assign follow_enabled    = res_q.follow_ext;
	assign fell_back         = fell_q;

	// internal clock runs exactly when internal is the provider
	a_int_matches_src: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.run_flags[0] == !st_q.src_is_ext)
		else $error("internal run flag out of step with provider");
	// output clock runs with whichever provider is running
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.run_flags[2] == (st_q.run_flags[1] | st_q.run_flags[0]))
		else $error("output run flag inconsistent");
	// dominance always tracks follow and external running
	a_dominance: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.dominant == (st_q.follow_ext | st_q.ext_running))
		else $error("dominance flag stale");
	// a fallback result always reports internal with follow cleared
	a_fell_internal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fell_q) |-> (!res_q.src_is_ext && !res_q.follow_ext))
		else $error("fallback result not on internal clock");

endmodule

// File: rtl/clock_source_transport_control_core.sv
// top level of clock source and transport control
//
//  channel   handshake            payload
//  input     in_valid/in_ready    opcode, now_ms, gate_level, flag_a, flag_b, flag_c
//  result    out_valid/out_ready  source_external .. fell_back, one beat per input beat
//  config    cfg_write            cfg_data -> watchdog timeout, no wait
//
// one event per cycle sustained while out_ready stays high; each event is a few
// flag updates and one 32-bit subtract-compare in the back stage
// from input accept to result valid an event passes the classify register,
// then the command queue, then the result register
// reset clears all transport state, run flags to internal and output, timeout 1000
// a stalled result register stops the back stage; the queue then fills and
// the front stalls the input once its own register is held

module clock_source_transport_control_core
	import cstc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [31:0] now_ms,
	input  logic [7:0]  gate_level,
	input  logic        flag_a,
	input  logic        flag_b,
	input  logic        flag_c,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        source_external,
	output logic        internal_run,
	output logic        midi_in_run,
	output logic        midi_out_run,
	output logic        external_dominant,
	output logic        latched_running,
	output logic        follow_enabled,
	output logic        fell_back
);

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop;
	cmd_t head_cmd;
	logic queue_empty;

	// front: accept and classify
	cstc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.now_ms     (now_ms),
		.gate_level (gate_level),
		.flag_a     (flag_a),
		.flag_b     (flag_b),
		.flag_c     (flag_c),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	// decoupling queue
	cstc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (queue_empty)
	);

	// back: execute and deliver results
	cstc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_data          (cfg_data),
		.queue_empty       (queue_empty),
		.head_cmd          (head_cmd),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.source_external   (source_external),
		.internal_run      (internal_run),
		.midi_in_run       (midi_in_run),
		.midi_out_run      (midi_out_run),
		.external_dominant (external_dominant),
		.latched_running   (latched_running),
		.follow_enabled    (follow_enabled),
		.fell_back         (fell_back)
	);

endmodule
